// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// File: hdl/wrhp_pkg.sv
// shared types, constants and magic-byte tables for the wav header parser
// no dependencies
package wrhp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FMT    = 2'd1,
    PH_STOP   = 2'd2
  } wrhp_phase_e;

  localparam logic [31:0] ID_FMT          = 32'h666D_7420;
  localparam logic [31:0] ID_DATA         = 32'h6461_7461;
  localparam logic [7:0]  FALLBACK_OFFSET = 8'd44;
  localparam logic [7:0]  FIRST_CHUNK     = 8'd12;
  localparam logic [7:0]  MAGIC_LAST      = 8'd11;
  localparam logic [7:0]  CHUNK_HDR_BYTES = 8'd8;
  localparam logic [31:0] FMT_MIN_SIZE    = 32'd16;
  localparam logic [15:0] NARROW_BITS     = 16'd16;
  localparam logic [15:0] DEF_CHANNELS    = 16'd2;
  localparam logic [31:0] DEF_RATE        = 32'd32000;
  localparam logic [15:0] DEF_BITS        = 16'd32;

  // one result transfer, fixed-width fields
  typedef struct packed {
    logic        is_wav;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic        slot_is_32bit;
    logic        expand_mono;
    logic [31:0] pcm_length;
  } wrhp_res_t;

  // expected byte at positions 0-11 ("RIFF" .... "WAVE")
  function automatic logic [7:0] magic_byte(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'h52;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h46;
      4'd3:    b = 8'h46;
      4'd8:    b = 8'h57;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h45;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // riff size bytes 4-7 are not checked
  function automatic logic magic_check(input logic [3:0] pos);
    logic c;
    case (pos)
      4'd4, 4'd5, 4'd6, 4'd7: c = 1'b0;
      default:                c = 1'b1;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/wrhp_in_stage.sv
// input register for byte and buffer length, holds while the parser stalls
// depends on nothing but its ports
module wrhp_in_stage #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             byte_in_i,
  input  logic [LENGTH_BITS-1:0] buffer_length_i,
  input  logic                   advance_i,
  output logic                   valid_o,
  output logic [7:0]             byte_o,
  output logic [LENGTH_BITS-1:0] length_o
);

  logic                   valid_q, valid_d;
  logic [7:0]             byte_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic                   take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_d    = (valid_q && !advance_i) || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_in_i;
      len_q  <= buffer_length_i;
    end
  end

  assign valid_o  = valid_q;
  assign byte_o   = byte_q;
  assign length_o = len_q;

endmodule

// File: hdl/wrhp_parser.sv
// per-byte parse state: magic check, chunk header walk, fmt capture, data chunk
// depends on wrhp_pkg and assert_macros.svh
`include "assert_macros.svh"
module wrhp_parser import wrhp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [7:0]             byte_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  logic                   out_ready_i,
  output logic                   fire_o,
  output logic                   res_valid_o,
  output wrhp_res_t              res_o,
  output logic [LENGTH_BITS-1:0] pcm_offset_o
);

  localparam int LB = LENGTH_BITS;
  // room for offset + 8 + 32-bit size + pad without wrap
  localparam int SW = ((LB > 32) ? LB : 32) + 3;

  wrhp_phase_e   phase_q, phase_d, phase_u;
  logic          magic_q, magic_d, magic_u;
  logic [LB-1:0] pos_q, pos_d;
  logic [31:0]   id_q, id_d, id_u;
  logic [31:0]   size_q, size_d, size_u;
  logic [3:0]    idx_q, idx_d, idx_u;
  logic [LB:0]   nco_q, nco_d, nco_u;
  logic [15:0]   ch_q, ch_d, ch_u;
  logic [31:0]   rate_q, rate_d, rate_u;
  logic [15:0]   bits_q, bits_d, bits_u;
  logic [LB-1:0] dco_q, dco_d, dco_u;
  logic [31:0]   dcs_q, dcs_d, dcs_u;

  logic          last;
  logic [LB:0]   hdr_diff;
  logic          hdr_hit;
  logic [2:0]    hdr_idx;
  logic [31:0]   size_new;
  logic [SW-1:0] body;
  logic [SW-1:0] chunk_end;
  logic [SW-1:0] next_off;

  assign last     = ({1'b0, pos_q} + (LB+1)'(1)) >= {1'b0, len_i};
  assign fire_o   = valid_i && (!last || out_ready_i);
  assign res_valid_o = valid_i && last && out_ready_i;

  // offset of this byte inside the current 8-byte chunk header
  assign hdr_diff = {1'b0, pos_q} - nco_q;
  assign hdr_hit  = ({1'b0, pos_q} >= nco_q) && (hdr_diff[LB:3] == '0);
  assign hdr_idx  = hdr_diff[2:0];

  always_comb begin
    size_new = size_q;
    case (hdr_idx[1:0])
      2'd0:    size_new[7:0]   = byte_i;
      2'd1:    size_new[15:8]  = byte_i;
      2'd2:    size_new[23:16] = byte_i;
      2'd3:    size_new[31:24] = byte_i;
      default: size_new        = size_q;
    endcase
  end

  assign body      = SW'(nco_q) + SW'(CHUNK_HDR_BYTES);
  assign chunk_end = body + SW'(size_new);
  assign next_off  = chunk_end + SW'(size_new[0]);

  // state after this byte
  always_comb begin
    phase_u = phase_q;
    magic_u = magic_q;
    id_u    = id_q;
    size_u  = size_q;
    idx_u   = idx_q;
    nco_u   = nco_q;
    ch_u    = ch_q;
    rate_u  = rate_q;
    bits_u  = bits_q;
    dco_u   = dco_q;
    dcs_u   = dcs_q;

    if ((pos_q < LB'(FIRST_CHUNK)) && magic_check(pos_q[3:0]) &&
        (byte_i != magic_byte(pos_q[3:0]))) begin
      magic_u = 1'b0;
      phase_u = PH_STOP;
    end

    case (phase_u)
      PH_FMT: begin
        case (idx_q)
          4'd2:    ch_u[7:0]     = byte_i;
          4'd3:    ch_u[15:8]    = byte_i;
          4'd4:    rate_u[7:0]   = byte_i;
          4'd5:    rate_u[15:8]  = byte_i;
          4'd6:    rate_u[23:16] = byte_i;
          4'd7:    rate_u[31:24] = byte_i;
          4'd14:   bits_u[7:0]   = byte_i;
          4'd15:   bits_u[15:8]  = byte_i;
          default: ;
        endcase
        idx_u = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          phase_u = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (hdr_hit) begin
          if (!hdr_idx[2]) begin
            id_u = {id_q[23:0], byte_i};
          end else begin
            size_u = size_new;
            if (hdr_idx[1:0] == 2'd3) begin
              if (chunk_end > SW'(len_i)) begin
                phase_u = PH_STOP;
              end else begin
                if ((id_q == ID_FMT) && (size_new >= FMT_MIN_SIZE)) begin
                  phase_u = PH_FMT;
                  idx_u   = '0;
                end else if (id_q == ID_DATA) begin
                  dco_u = body[LB-1:0];
                  dcs_u = size_new;
                end
                nco_u = next_off[LB:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // the last byte of a buffer returns everything to reset values
  always_comb begin
    if (last) begin
      phase_d = PH_HEADER;
      magic_d = 1'b1;
      pos_d   = '0;
      id_d    = '0;
      size_d  = '0;
      idx_d   = '0;
      nco_d   = (LB+1)'(FIRST_CHUNK);
      ch_d    = DEF_CHANNELS;
      rate_d  = DEF_RATE;
      bits_d  = DEF_BITS;
      dco_d   = '0;
      dcs_d   = '0;
    end else begin
      phase_d = phase_u;
      magic_d = magic_u;
      pos_d   = pos_q + LB'(1);
      id_d    = id_u;
      size_d  = size_u;
      idx_d   = idx_u;
      nco_d   = nco_u;
      ch_d    = ch_u;
      rate_d  = rate_u;
      bits_d  = bits_u;
      dco_d   = dco_u;
      dcs_d   = dcs_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      magic_q <= 1'b1;
      pos_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      idx_q   <= '0;
      nco_q   <= (LB+1)'(FIRST_CHUNK);
      ch_q    <= DEF_CHANNELS;
      rate_q  <= DEF_RATE;
      bits_q  <= DEF_BITS;
      dco_q   <= '0;
      dcs_q   <= '0;
    end else if (fire_o) begin
      phase_q <= phase_d;
      magic_q <= magic_d;
      pos_q   <= pos_d;
      id_q    <= id_d;
      size_q  <= size_d;
      idx_q   <= idx_d;
      nco_q   <= nco_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      dco_q   <= dco_d;
      dcs_q   <= dcs_d;
    end
  end

  // result fields from the state after the last byte
  always_comb begin
    res_o.is_wav        = magic_u && (pos_q >= LB'(MAGIC_LAST));
    res_o.channels      = ch_u;
    res_o.rate_hz       = rate_u;
    res_o.sample_bits   = bits_u;
    res_o.slot_is_32bit = bits_u > NARROW_BITS;
    res_o.expand_mono   = (ch_u == 16'd1) && (bits_u == NARROW_BITS);
    if (dcs_u != '0) begin
      res_o.pcm_length = dcs_u;
    end else if (len_i > LB'(FALLBACK_OFFSET)) begin
      res_o.pcm_length = 32'(len_i - LB'(FALLBACK_OFFSET));
    end else begin
      res_o.pcm_length = '0;
    end
    pcm_offset_o = (dco_u != '0) ? dco_u : LB'(FALLBACK_OFFSET);
  end

  `ASSERT_CLK(a_idx_in_fmt, (idx_q != '0) |-> (phase_q == PH_FMT), "fmt index outside body")
  `ASSERT_CLK(a_fmt_needs_magic, (phase_q == PH_FMT) |-> magic_q, "fmt body without magic")
  `ASSERT_NEVER(a_bad_magic_walks, !magic_q && (phase_q != PH_STOP), "walk after magic failure")

endmodule

// File: hdl/wrhp_out_stage.sv
// result register, holds a result until the receiver takes it
// depends on wrhp_pkg
module wrhp_out_stage import wrhp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  wrhp_res_t              res_i,
  input  logic [LENGTH_BITS-1:0] pcm_offset_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output wrhp_res_t              res_o,
  output logic [LENGTH_BITS-1:0] pcm_offset_o
);

  logic                   valid_q, valid_d;
  wrhp_res_t              res_q;
  logic [LENGTH_BITS-1:0] start_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q   <= res_i;
      start_q <= pcm_offset_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign res_o        = res_q;
  assign pcm_offset_o = start_q;

endmodule

// File: hdl/wav_riff_header_parser.sv
// top level of the riff/wave header parser
// depends on wrhp_pkg, wrhp_in_stage, wrhp_parser, wrhp_out_stage
//
// usage:
//   input channel: one buffer byte per transfer (byte_in_i), in order from
//   offset zero, with the buffer's total length (buffer_length_i) on every
//   byte. a transfer happens when in_valid_i is high and in_stall_o is low.
//   output channel: one result transfer per buffer, made for its last byte
//   (position + 1 >= buffer_length). it carries is_wav, the fmt fields with
//   their defaults (2 channels, 32000 Hz, 32 bits), the derived slot and mono
//   flags, and the pcm offset/length (data chunk, else offset 44).
// result path: a buffer's last byte is held in the input register, then its
//   result in the result register until the receiver takes it.
// throughput: one byte per cycle unless a held result blocks a last byte;
//   each byte takes one register-to-register step of compares and counter updates.
// reset: clears both pipeline valids and puts the parse state back to the
//   start of a buffer; after each buffer the state returns there by itself.
// stall: a held result blocks only the next buffer's last byte; other bytes
//   keep flowing while the result waits. in_stall_o rises only then.
module wav_riff_header_parser import wrhp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte stream
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             byte_in_i,
  input  logic [LENGTH_BITS-1:0] buffer_length_i,
  // parse result
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_wav_o,
  output logic [15:0]            channels_o,
  output logic [31:0]            rate_hz_o,
  output logic [15:0]            sample_bits_o,
  output logic                   slot_is_32bit_o,
  output logic                   expand_mono_o,
  output logic [LENGTH_BITS-1:0] pcm_offset_o,
  output logic [31:0]            pcm_length_o
);

  // registered byte waiting for the parser
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic [LENGTH_BITS-1:0] s1_len;
  // parser handshake with the result register
  logic                   fire;
  logic                   res_load;
  logic                   out_ready;
  wrhp_res_t              res_next;
  wrhp_res_t              res_out;
  logic [LENGTH_BITS-1:0] start_next;

  wrhp_in_stage #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .buffer_length_i(buffer_length_i),
    .advance_i      (fire),
    .valid_o        (s1_valid),
    .byte_o         (s1_byte),
    .length_o       (s1_len)
  );

  // parse state advances on every byte; the last byte also needs room
  // in the result register
  wrhp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .byte_i      (s1_byte),
    .len_i       (s1_len),
    .out_ready_i (out_ready),
    .fire_o      (fire),
    .res_valid_o (res_load),
    .res_o       (res_next),
    .pcm_offset_o(start_next)
  );

  wrhp_out_stage #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_next),
    .pcm_offset_i(start_next),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out),
    .pcm_offset_o(pcm_offset_o)
  );

  // result fields out to their own ports
  assign is_wav_o        = res_out.is_wav;
  assign channels_o      = res_out.channels;
  assign rate_hz_o       = res_out.rate_hz;
  assign sample_bits_o   = res_out.sample_bits;
  assign slot_is_32bit_o = res_out.slot_is_32bit;
  assign expand_mono_o   = res_out.expand_mono;
  assign pcm_length_o    = res_out.pcm_length;

endmodule

// File: verif/tb_wav_riff_header_parser.sv
// self-checking testbench for wav_riff_header_parser: byte streams of riff/wave
// buffers in, one format summary per buffer out, checked against a local predictor
// depends on wrhp_pkg and the wav_riff_header_parser rtl
module tb_wav_riff_header_parser import wrhp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LEN_W          = 24;
  localparam int unsigned MAX_LEN        = 2 ** LEN_W - 1;
  localparam int          ITEMS          = 1650;
  localparam int          MIN_RESULTS    = 48;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          HOLD_STEP      = 750;
  localparam int          PHASE_BYTES    = 200;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = 8;

  localparam logic [31:0] RIFF_ID     = 32'h5249_4646;
  localparam logic [31:0] WAVE_ID     = 32'h5741_5645;
  // expected bytes 0-11, byte 0 in the top bits; the riff size is not checked
  localparam logic [95:0] MAGIC_BYTES = {RIFF_ID, 32'h0, WAVE_ID};
  localparam logic [11:0] MAGIC_MASK  = 12'b1111_0000_1111;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // one byte transfer as queued for the driver
  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] blen;
  } byte_xfer_t;

  // the summary the block reports for one buffer
  typedef struct packed {
    logic             is_wav;
    logic [15:0]      channels;
    logic [31:0]      rate;
    logic [15:0]      bits;
    logic             slot32;
    logic             mono;
    logic [LEN_W-1:0] pcm_off;
    logic [31:0]      pcm_len;
  } wav_summary_t;

  // clock, reset and dut ports; every input known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_r  = 1'b0;
  logic [7:0]       byte_r      = 8'h00;
  logic [LEN_W-1:0] blen_r      = LEN_W'(1);
  logic             out_stall_r = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             is_wav_o;
  logic [15:0]      channels_o;
  logic [31:0]      rate_hz_o;
  logic [15:0]      sample_bits_o;
  logic             slot_is_32bit_o;
  logic             expand_mono_o;
  logic [LEN_W-1:0] pcm_offset_o;
  logic [31:0]      pcm_length_o;

  byte_xfer_t   pending_q[$];
  wav_summary_t summary_q[$];
  logic [7:0]   frame_q[$];

  int bytes_in     = 0;
  int buffers_made = 0;
  int fail_cnt     = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  int next_hold_at = 100;

  idle_mode_e idle_mode;
  int         send_idle_pct;
  int         stall_pct;

  // predictor state for the buffer in flight
  logic [LEN_W-1:0] p_pos;
  wrhp_phase_e      p_walk;
  logic             p_magic;
  logic [31:0]      p_id;
  logic [31:0]      p_size;
  int               p_fmt_idx;
  logic [32:0]      p_chunk_base;
  logic [15:0]      p_ch;
  logic [31:0]      p_rate;
  logic [15:0]      p_bits;
  logic [LEN_W-1:0] p_data_off;
  logic [31:0]      p_data_len;

  always #6 clk_i = ~clk_i;

  wav_riff_header_parser #(
    .LENGTH_BITS(LEN_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_r),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_r),
    .buffer_length_i(blen_r),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_r),
    .is_wav_o       (is_wav_o),
    .channels_o     (channels_o),
    .rate_hz_o      (rate_hz_o),
    .sample_bits_o  (sample_bits_o),
    .slot_is_32bit_o(slot_is_32bit_o),
    .expand_mono_o  (expand_mono_o),
    .pcm_offset_o   (pcm_offset_o),
    .pcm_length_o   (pcm_length_o)
  );

  // idling rotates every PHASE_BYTES accepted bytes: none, sender, receiver, both
  always_comb begin
    idle_mode     = idle_mode_e'(2'((bytes_in / PHASE_BYTES) % 4));
    send_idle_pct = (idle_mode == IDLE_SEND) ? 72 : (idle_mode == IDLE_BOTH) ? 36 : 0;
    stall_pct     = (idle_mode == IDLE_RECV) ? 72 : (idle_mode == IDLE_BOTH) ? 36 : 0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // parse state at the start of a buffer
  task automatic clear_parser();
    p_pos        = '0;
    p_walk       = PH_HEADER;
    p_magic      = 1'b1;
    p_id         = '0;
    p_size       = '0;
    p_fmt_idx    = 0;
    p_chunk_base = 33'(FIRST_CHUNK);
    p_ch         = DEF_CHANNELS;
    p_rate       = DEF_RATE;
    p_bits       = DEF_BITS;
    p_data_off   = '0;
    p_data_len   = '0;
  endtask

  // advance the parse by one accepted byte; on the last byte of a buffer
  // queue the summary the block has to report and start over
  task automatic parse_byte(input logic [7:0] b, input logic [LEN_W-1:0] blen);
    longint unsigned rel;
    logic [63:0]     body;
    int              mi;
    wav_summary_t    s;
    // magic compare on bytes 0-3 and 8-11; a miss stops the walk for good
    if (p_pos < 12) begin
      mi = int'(p_pos);
      if (MAGIC_MASK[11 - mi] && b != MAGIC_BYTES[95 - 8 * mi -: 8]) begin
        p_magic = 1'b0;
        p_walk  = PH_STOP;
      end
    end
    if (p_walk == PH_FMT) begin
      // only the first 16 body bytes of a fmt chunk are looked at
      case (p_fmt_idx)
        2:          p_ch[7:0]                      = b;
        3:          p_ch[15:8]                     = b;
        4, 5, 6, 7: p_rate[8 * (p_fmt_idx - 4) +: 8] = b;
        14:         p_bits[7:0]                    = b;
        15:         p_bits[15:8]                   = b;
        default:    ;
      endcase
      p_fmt_idx++;
      if (p_fmt_idx >= 16) p_walk = PH_HEADER;
    end else if (p_walk == PH_HEADER && 33'(p_pos) >= p_chunk_base) begin
      rel = 64'(p_pos) - 64'(p_chunk_base);
      if (rel < 4) begin
        // chunk id arrives most significant byte first
        p_id = {p_id[23:0], b};
      end else if (rel < 8) begin
        p_size[8 * (int'(rel) - 4) +: 8] = b;
        if (rel == 7) begin
          // sums kept wide so a huge size can never wrap into a fit
          body = 64'(p_chunk_base) + 64'(CHUNK_HDR_BYTES);
          if (body + 64'(p_size) > 64'(blen)) begin
            p_walk = PH_STOP;
          end else begin
            if (p_id == ID_FMT && p_size >= FMT_MIN_SIZE) begin
              p_walk    = PH_FMT;
              p_fmt_idx = 0;
            end else if (p_id == ID_DATA) begin
              // a later data chunk replaces an earlier one
              p_data_off = body[LEN_W-1:0];
              p_data_len = p_size;
            end
            // odd chunk sizes carry one pad byte
            p_chunk_base = 33'(body + 64'(p_size) + 64'(p_size[0]));
          end
        end
      end
    end
    if ({1'b0, p_pos} + 1 < {1'b0, blen}) begin
      p_pos = p_pos + 1'b1;
    end else begin
      // last byte: the length of this very byte decides it
      s.is_wav   = p_magic && (p_pos >= LEN_W'(MAGIC_LAST));
      s.channels = p_ch;
      s.rate     = p_rate;
      s.bits     = p_bits;
      s.slot32   = (p_bits > NARROW_BITS);
      s.mono     = (p_ch == 16'd1) && (p_bits == NARROW_BITS);
      s.pcm_off  = (p_data_off != 0) ? p_data_off : LEN_W'(FALLBACK_OFFSET);
      if (p_data_len != 0) s.pcm_len = p_data_len;
      else if (32'(blen) > 32'(FALLBACK_OFFSET)) s.pcm_len = 32'(blen) - 32'(FALLBACK_OFFSET);
      else s.pcm_len = '0;
      summary_q.push_back(s);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  // chunk ids go out in text order
  task automatic put_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) frame_q.push_back(id[8 * i +: 8]);
  endtask

  // sizes and fmt fields are little endian
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) frame_q.push_back(v[8 * i +: 8]);
  endtask

  // queue the first n bytes of the frame as one buffer; a nonzero lead_len
  // is sent as the length on every byte but the last
  task automatic emit_frame(input int n, input logic [LEN_W-1:0] final_len,
                            input logic [LEN_W-1:0] lead_len);
    byte_xfer_t x;
    for (int i = 0; i < n; i++) begin
      x.data = frame_q[i];
      x.blen = (lead_len != 0 && i != n - 1) ? lead_len : final_len;
      pending_q.push_back(x);
    end
    frame_q.delete();
    buffers_made++;
  endtask

  // riff/wave buffer with up to three random chunks; an oversized header ends them
  task automatic build_wav();
    int          n_chunks;
    int          kind;
    logic [31:0] csize;
    logic [31:0] chunk_id;
    logic [31:0] rate;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [7:0]  body[$];
    put_id(RIFF_ID);
    put_le($urandom, 4);
    put_id(WAVE_ID);
    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c < n_chunks; c++) begin
      kind = $urandom_range(0, 9);
      body.delete();
      if (kind == 8) begin
        // header whose body can never fit: the walk ends here
        chunk_id = ($urandom_range(0, 1) == 0) ? ID_DATA : ID_FMT;
        csize    = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                : 32'($urandom_range(256, 32'hFFFF_FFFE));
        put_id(chunk_id);
        put_le(csize, 4);
        break;
      end
      if (kind <= 2 || kind == 9) begin
        chunk_id = ID_FMT;
        // kind 9 is a fmt chunk too short to be used
        if (kind == 9) csize = 32'($urandom_range(0, 15));
        else if ($urandom_range(0, 2) == 0) csize = 32'($urandom_range(17, 22));
        else csize = FMT_MIN_SIZE;
      end else if (kind <= 5) begin
        chunk_id = ID_DATA;
        csize    = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
      end else begin
        chunk_id = $urandom;
        csize    = 32'($urandom_range(0, 12));
      end
      repeat (csize) body.push_back(8'($urandom));
      if (chunk_id == ID_FMT && csize >= FMT_MIN_SIZE) begin
        // bias toward the values that flip the mono and slot flags
        case ($urandom_range(0, 2))
          0:       ch = 16'd1;
          1:       ch = 16'd2;
          default: ch = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       bits = 16'd8;
          1:       bits = 16'd16;
          2:       bits = 16'd24;
          3:       bits = 16'd32;
          default: bits = 16'($urandom);
        endcase
        rate     = ($urandom_range(0, 1) == 0) ? 32'd48000 : $urandom;
        body[2]  = ch[7:0];
        body[3]  = ch[15:8];
        for (int k = 0; k < 4; k++) body[4 + k] = rate[8 * k +: 8];
        body[14] = bits[7:0];
        body[15] = bits[15:8];
      end
      put_id(chunk_id);
      put_le(csize, 4);
      foreach (body[k]) frame_q.push_back(body[k]);
      if (csize[0]) frame_q.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    int n;
    int k;
    // directed: one-byte buffer of all ones
    frame_q.push_back(8'hFF);
    emit_frame(1, LEN_W'(1), '0);
    // length at its maximum on the first byte, then shrinking to end the buffer
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    emit_frame(2, LEN_W'(2), LEN_W'(MAX_LEN));
    frame_q.push_back(8'hA5);
    emit_frame(1, LEN_W'(1), '0);
    // magic prefix cut short: not a wav buffer
    put_id(RIFF_ID);
    frame_q.push_back(8'h00);
    emit_frame(5, LEN_W'(5), '0);
    // magic only, twelve bytes: wav with nothing but defaults
    put_id(RIFF_ID);
    put_le(32'hFFFF_FFFF, 4);
    put_id(WAVE_ID);
    emit_frame(12, LEN_W'(12), '0);

    // random: mostly well-formed buffers, some with broken magic, some noise
    while (pending_q.size() < ITEMS || buffers_made < MIN_RESULTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        build_wav();
        if (pick >= 72) begin
          // spoil one checked magic byte
          k = $urandom_range(0, 7);
          if (k >= 4) k = k + 4;
          frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
        end
      end else begin
        repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
      end
      n    = frame_q.size();
      pick = $urandom_range(0, 99);
      // a cut buffer leaves chunks hanging past its end
      if (pick < 20) n = $urandom_range(1, n);
      if (pick >= 92 && n > 1) emit_frame(n, LEN_W'(n), LEN_W'($urandom_range(n, MAX_LEN)));
      else emit_frame(n, LEN_W'(n), '0);
    end

    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all bytes out, every summary back, then a short drain
    while (pending_q.size() != 0 || in_valid_r) @(posedge clk_i);
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, holds a stalled byte unchanged
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    byte_xfer_t nxt;
    if (!rst_ni) begin
      in_valid_r <= 1'b0;
    end else begin
      if (in_valid_r && !in_stall_o) begin
        parse_byte(byte_r, blen_r);
        bytes_in <= bytes_in + 1;
      end
      // a new byte only once the current one is gone
      if (!in_valid_r || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid_r <= 1'b1;
          byte_r     <= nxt.data;
          blen_r     <= nxt.blen;
        end else begin
          in_valid_r <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each summary transfer, drives the result stall
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    wav_summary_t want;
    if (!rst_ni) begin
      out_stall_r <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_r) begin
        if (summary_q.size() == 0) begin
          $display("%0t ns: summary with none expected, actual offset %0h length %0h",
                   $time, pcm_offset_o, pcm_length_o);
          fail_cnt++;
        end else begin
          want = summary_q.pop_front();
          check_field("is_wav", 32'(want.is_wav), 32'(is_wav_o));
          check_field("channels", 32'(want.channels), 32'(channels_o));
          check_field("rate_hz", want.rate, rate_hz_o);
          check_field("sample_bits", 32'(want.bits), 32'(sample_bits_o));
          check_field("slot_is_32bit", 32'(want.slot32), 32'(slot_is_32bit_o));
          check_field("expand_mono", 32'(want.mono), 32'(expand_mono_o));
          check_field("pcm_offset", 32'(want.pcm_off), 32'(pcm_offset_o));
          check_field("pcm_length", want.pcm_len, pcm_length_o);
        end
      end
      // long hold-offs at set byte counts, all in no-idle phases, so a
      // held summary backs up into the input while the sender keeps going
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_r <= 1'b1;
      end else if (bytes_in >= next_hold_at) begin
        hold_left    <= HOLD_CYCLES;
        next_hold_at <= next_hold_at + HOLD_STEP;
        out_stall_r  <= 1'b1;
      end else begin
        out_stall_r <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_r && !in_stall_o) || (out_valid_o && !out_stall_r)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: wav_riff_header_parser.f
+incdir+hdl
hdl/wrhp_pkg.sv
hdl/wrhp_in_stage.sv
hdl/wrhp_parser.sv
hdl/wrhp_out_stage.sv
hdl/wav_riff_header_parser.sv
verif/tb_wav_riff_header_parser.sv
